// File: rtl/tlmc_pkg.sv
// Shared types and constants of the traffic light mode controller.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package tlmc_pkg;

  // Field widths
  localparam int unsigned ModeW    = 8;
  localparam int unsigned LightW   = 2;
  localparam int unsigned LampW    = 3;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned CfgIdxW  = 8;

  // Saturation point of the elapsed counter
  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  // Mode codes
  localparam logic [ModeW-1:0] ModeCycle       = 8'd10;
  localparam logic [ModeW-1:0] ModeBlinkOrange = 8'd20;
  localparam logic [ModeW-1:0] ModeBlinkGreen  = 8'd30;
  localparam logic [ModeW-1:0] ModeBlinkRed    = 8'd40;
  localparam logic [ModeW-1:0] ModeManRed      = 8'd50;
  localparam logic [ModeW-1:0] ModeManGreen    = 8'd52;
  localparam logic [ModeW-1:0] ModeFullRed     = 8'd60;
  localparam logic [ModeW-1:0] ModeFullOrange  = 8'd61;
  localparam logic [ModeW-1:0] ModeFullGreen   = 8'd62;

  // Tracked light codes, also bit positions in the lamp vector
  localparam logic [LightW-1:0] LightRed    = 2'd0;
  localparam logic [LightW-1:0] LightOrange = 2'd1;
  localparam logic [LightW-1:0] LightGreen  = 2'd2;
  localparam logic [LightW-1:0] LightNone   = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGreenTime  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgRedTime    = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgOrangeTime = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgBlinkHalf  = 8'd3;

  // Reset values
  localparam logic [TimeW-1:0]  GreenTimeRst  = 16'd10000;
  localparam logic [TimeW-1:0]  RedTimeRst    = 16'd10000;
  localparam logic [TimeW-1:0]  OrangeTimeRst = 16'd3000;
  localparam logic [TimeW-1:0]  BlinkHalfRst  = 16'd600;
  localparam logic [LampW-1:0]  LampsRst      = 3'b001;

  typedef struct packed {
    logic [TimeW-1:0] green_time;
    logic [TimeW-1:0] red_time;
    logic [TimeW-1:0] orange_time;
    logic [TimeW-1:0] blink_half;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [LampW-1:0]    lamps;
    logic [LightW-1:0]   light;
    logic [ElapsedW-1:0] elapsed;
    logic [TimeW-1:0]    phase_len;
    logic                blink;
  } state_t;

endpackage

`default_nettype wire

// File: rtl/tlmc_cfg_regs.sv
// Configuration register file of the traffic light mode controller.
// Depends on tlmc_pkg.
`default_nettype none

module tlmc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tlmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tlmc_pkg::TimeW-1:0]    cfg_wdata_i,
  output tlmc_pkg::cfg_t                     cfg_o
);

  tlmc_pkg::cfg_t cfg_q;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_time  <= tlmc_pkg::GreenTimeRst;
      cfg_q.red_time    <= tlmc_pkg::RedTimeRst;
      cfg_q.orange_time <= tlmc_pkg::OrangeTimeRst;
      cfg_q.blink_half  <= tlmc_pkg::BlinkHalfRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlmc_pkg::CfgGreenTime:  cfg_q.green_time  <= cfg_wdata_i;
        tlmc_pkg::CfgRedTime:    cfg_q.red_time    <= cfg_wdata_i;
        tlmc_pkg::CfgOrangeTime: cfg_q.orange_time <= cfg_wdata_i;
        tlmc_pkg::CfgBlinkHalf:  cfg_q.blink_half  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/tlmc_step.sv
// Next-state logic for one request: tick or mode command.
// Purely combinational; depends on tlmc_pkg.
`default_nettype none

module tlmc_step (
  input  wire tlmc_pkg::state_t            state_i,
  input  wire tlmc_pkg::cfg_t              cfg_i,
  input  wire logic                        func_i,
  input  wire logic [tlmc_pkg::ModeW-1:0]  mode_code_i,
  output tlmc_pkg::state_t                 state_o
);

  tlmc_pkg::state_t s;
  logic [tlmc_pkg::LightW-1:0] blink_lamp;
  logic                        do_blink;
  logic                        new_blink;

  always_comb begin
    s          = state_i;
    blink_lamp = tlmc_pkg::LightOrange;
    do_blink   = 1'b0;
    new_blink  = 1'b0;

    // Count the tick or enter a new mode
    if (!func_i) begin
      if (s.elapsed != tlmc_pkg::ElapsedMax) begin
        s.elapsed = s.elapsed + 1'b1;
      end
    end else if (mode_code_i != s.mode) begin
      case (mode_code_i)
        tlmc_pkg::ModeCycle: begin
          s.lamps = tlmc_pkg::LampsRst;
          s.light = tlmc_pkg::LightRed;
        end
        tlmc_pkg::ModeBlinkOrange, tlmc_pkg::ModeBlinkGreen, tlmc_pkg::ModeBlinkRed,
        tlmc_pkg::ModeFullRed, tlmc_pkg::ModeFullOrange, tlmc_pkg::ModeFullGreen: begin
          if (s.light != tlmc_pkg::LightNone) begin
            s.lamps[s.light] = 1'b0;
          end
        end
        default: ;
      endcase
      s.mode = mode_code_i;
    end

    // Run the action of the active mode
    case (s.mode)
      tlmc_pkg::ModeCycle: begin
        if (s.elapsed > {1'b0, s.phase_len}) begin
          s.elapsed = '0;
          case (s.light)
            tlmc_pkg::LightRed: begin
              s.lamps[tlmc_pkg::LightRed]   = 1'b0;
              s.lamps[tlmc_pkg::LightGreen] = 1'b1;
              s.phase_len = cfg_i.green_time;
              s.light     = tlmc_pkg::LightGreen;
            end
            tlmc_pkg::LightOrange: begin
              s.lamps[tlmc_pkg::LightOrange] = 1'b0;
              s.lamps[tlmc_pkg::LightRed]    = 1'b1;
              s.phase_len = cfg_i.red_time;
              s.light     = tlmc_pkg::LightRed;
            end
            tlmc_pkg::LightGreen: begin
              s.lamps[tlmc_pkg::LightGreen]  = 1'b0;
              s.lamps[tlmc_pkg::LightOrange] = 1'b1;
              s.phase_len = cfg_i.orange_time;
              s.light     = tlmc_pkg::LightOrange;
            end
            default: s.phase_len = '0;
          endcase
        end
      end
      tlmc_pkg::ModeBlinkGreen: begin
        do_blink   = 1'b1;
        blink_lamp = tlmc_pkg::LightGreen;
      end
      tlmc_pkg::ModeBlinkRed: begin
        do_blink   = 1'b1;
        blink_lamp = tlmc_pkg::LightRed;
      end
      tlmc_pkg::ModeManRed, tlmc_pkg::ModeFullRed: begin
        s.lamps = 3'b001;
        s.light = tlmc_pkg::LightRed;
      end
      tlmc_pkg::ModeFullOrange: begin
        s.lamps = 3'b010;
        s.light = tlmc_pkg::LightOrange;
      end
      tlmc_pkg::ModeManGreen, tlmc_pkg::ModeFullGreen: begin
        s.lamps = 3'b100;
        s.light = tlmc_pkg::LightGreen;
      end
      default: begin
        do_blink   = 1'b1;
        blink_lamp = tlmc_pkg::LightOrange;
      end
    endcase

    // Blink: track the lamp by phase, toggle when the half period expires
    if (do_blink) begin
      s.light = s.blink ? blink_lamp : tlmc_pkg::LightNone;
      if (s.elapsed > {1'b0, cfg_i.blink_half}) begin
        s.elapsed  = '0;
        new_blink  = ~s.blink;
        s.blink    = new_blink;
        s.lamps[blink_lamp] = ~new_blink;
      end
    end

    state_o = s;
  end

endmodule

`default_nettype wire

// File: rtl/traffic_light_mode_controller_core.sv
// Traffic light mode controller: request register, step logic, result register.
// Path: an accepted request waits in the request register, then loads the result register.
// Throughput: one request per cycle; a stalled result holds the request register full.
// Reset: asynchronous, active low; mode 10, red lit, elapsed cleared, config at defaults.
// Depends on tlmc_pkg, tlmc_cfg_regs and tlmc_step.
`default_nettype none

module traffic_light_mode_controller_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tlmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tlmc_pkg::TimeW-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output wire logic                          in_ready_o,
  input  wire logic                          func_i,
  input  wire logic [tlmc_pkg::ModeW-1:0]    mode_code_i,
  output wire logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output wire logic                          red_lit_o,
  output wire logic                          orange_lit_o,
  output wire logic                          green_lit_o,
  output wire logic [tlmc_pkg::ModeW-1:0]    mode_now_o,
  output wire logic [tlmc_pkg::LightW-1:0]   light_now_o
);

  tlmc_pkg::cfg_t   cfg;
  tlmc_pkg::state_t state_q, state_d;

  logic                        req_valid_q;
  logic                        req_func_q;
  logic [tlmc_pkg::ModeW-1:0]  req_code_q;
  logic                        res_valid_q;
  logic [tlmc_pkg::LampW-1:0]  res_lamps_q;
  logic [tlmc_pkg::ModeW-1:0]  res_mode_q;
  logic [tlmc_pkg::LightW-1:0] res_light_q;
  logic                        advance;

  tlmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tlmc_step u_step (
    .state_i     (state_q),
    .cfg_i       (cfg),
    .func_i      (req_func_q),
    .mode_code_i (req_code_q),
    .state_o     (state_d)
  );

  // Move the held request into the result register when it is free
  assign advance    = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_func_q <= func_i;
      req_code_q <= mode_code_i;
    end
  end

  // Controller state, updated once per processed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= tlmc_pkg::ModeCycle;
      state_q.lamps     <= tlmc_pkg::LampsRst;
      state_q.light     <= tlmc_pkg::LightRed;
      state_q.elapsed   <= '0;
      state_q.phase_len <= tlmc_pkg::RedTimeRst;
      state_q.blink     <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_lamps_q <= state_d.lamps;
      res_mode_q  <= state_d.mode;
      res_light_q <= state_d.light;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign red_lit_o    = res_lamps_q[tlmc_pkg::LightRed];
  assign orange_lit_o = res_lamps_q[tlmc_pkg::LightOrange];
  assign green_lit_o  = res_lamps_q[tlmc_pkg::LightGreen];
  assign mode_now_o   = res_mode_q;
  assign light_now_o  = res_light_q;

endmodule

`default_nettype wire
